// ===== src/qpwu_pkg.sv =====
`timescale 1ns / 1ps

package qpwu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_STAGES    = 32;

    localparam logic [1:0] REG_EPSILON = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_MU      = 2'd2;
    localparam logic [1:0] REG_SHRINK  = 2'd3;

    localparam logic [30:0]        EPSILON_RST = 31'd65536;
    localparam logic signed [31:0] DECAY_RST   = 32'sd0;
    localparam logic [30:0]        MU_RST      = 31'd114688;
    localparam logic [30:0]        SHRINK_RST  = 31'd41704;

    localparam logic signed [63:0] W32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] W32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] sd;
        logic signed [63:0] part;
        logic               use_quad;
        logic               den_zero;
        logic               num_neg;
        logic               num_zero;
        logic               q_neg;
        logic               ovf;
        logic               flag;
    } side_t;

endpackage

// ===== src/quickprop_weight_update.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle; the 32-stage restoring divider is fully pipelined.
// The whole pipeline holds while the output register waits for out_ready.
// Reset (rst_n, async, active low) clears valid bits and loads register defaults.
module quickprop_weight_update #(
    parameter int FRAC_BITS = qpwu_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] weight_in,
    input  logic signed [31:0] last_step,
    input  logic signed [31:0] slope_in,
    input  logic signed [31:0] prev_slope_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] weight_out,
    output logic signed [31:0] step_out,
    output logic signed [31:0] prev_slope_out,
    output logic               saturated,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int NS = qpwu_pkg::DIV_STAGES;

    logic [30:0]        eps_reg;
    logic signed [31:0] decay_reg;
    logic [30:0]        mu_reg;
    logic [30:0]        shrink_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg    <= qpwu_pkg::EPSILON_RST;
            decay_reg  <= qpwu_pkg::DECAY_RST;
            mu_reg     <= qpwu_pkg::MU_RST;
            shrink_reg <= qpwu_pkg::SHRINK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                qpwu_pkg::REG_EPSILON: eps_reg    <= cfg_data[30:0];
                qpwu_pkg::REG_DECAY:   decay_reg  <= cfg_data;
                qpwu_pkg::REG_MU:      mu_reg     <= cfg_data[30:0];
                qpwu_pkg::REG_SHRINK:  shrink_reg <= cfg_data[30:0];
                default:               eps_reg    <= eps_reg;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: decay product
    logic               v1_reg;
    logic signed [31:0] w1_reg, d1_reg, s1_reg, p1_reg;
    logic signed [63:0] pdw1_reg;

    // stage 2: decayed slope
    logic               v2_reg;
    logic signed [31:0] w2_reg, d2_reg, p2_reg, sd2_reg;
    logic               f2_reg;
    logic signed [64:0] sd_sum;
    logic signed [31:0] sd_next;
    logic               f2_next;

    // stage 3: products
    logic               v3_reg;
    logic signed [31:0] w3_reg, d3_reg, sd3_reg;
    logic               f3_reg;
    logic signed [63:0] meps3_reg, mmu3_reg, mthr3_reg, mnum3_reg;
    logic signed [32:0] den3_reg;

    // stage 4: term selection, divider setup
    qpwu_pkg::side_t    side_next;
    logic signed [63:0] thr, gterm, muterm, part_next;
    logic               g_on, mu_on, q_on;
    logic [63:0]        nmag;
    logic [32:0]        dmag;

    // divider pipeline
    logic               dv_reg   [0:NS];
    qpwu_pkg::side_t    dside_reg[0:NS];
    logic [32:0]        drem_reg [0:NS];
    logic [31:0]        dlow_reg [0:NS];
    logic [32:0]        ddiv_reg [0:NS];
    logic [32:0]        drem_next[0:NS-1];
    logic [31:0]        dlow_next[0:NS-1];

    // final sum
    logic               vf_reg;
    logic signed [31:0] wf_reg, sf_reg, stf_reg;
    logic               ff_reg;
    logic signed [63:0] qv, stsum;
    logic               fq, fs;
    logic signed [31:0] st_next;

    // output
    logic signed [31:0] wo_reg, so_reg, po_reg;
    logic               fo_reg;
    logic signed [32:0] nw_sum;
    logic signed [31:0] nw_next;
    logic               fw;

    always_comb
    begin
        sd_sum  = 65'(s1_reg) + 65'(pdw1_reg >>> FRAC_BITS);
        f2_next = 1'b0;
        if (sd_sum > 65'(qpwu_pkg::W32_MAX))
        begin
            sd_next = 32'(qpwu_pkg::W32_MAX);
            f2_next = 1'b1;
        end
        else if (sd_sum < 65'(qpwu_pkg::W32_MIN))
        begin
            sd_next = 32'(qpwu_pkg::W32_MIN);
            f2_next = 1'b1;
        end
        else
        begin
            sd_next = sd_sum[31:0];
        end
    end

    always_comb
    begin
        thr    = mthr3_reg >>> FRAC_BITS;
        gterm  = meps3_reg >>> FRAC_BITS;
        muterm = mmu3_reg >>> FRAC_BITS;
        g_on   = 1'b0;
        mu_on  = 1'b0;
        q_on   = 1'b0;
        if (d3_reg < 0)
        begin
            g_on  = sd3_reg > 0;
            mu_on = 64'(sd3_reg) >= thr;
            q_on  = !mu_on;
        end
        else if (d3_reg > 0)
        begin
            g_on  = sd3_reg < 0;
            mu_on = 64'(sd3_reg) <= thr;
            q_on  = !mu_on;
        end
        else
        begin
            g_on = 1'b1;
        end
        part_next = (g_on ? -gterm : 64'sd0) + (mu_on ? muterm : 64'sd0);
        nmag      = mnum3_reg[63] ? 64'(-mnum3_reg) : 64'(mnum3_reg);
        dmag      = den3_reg[32] ? 33'(-den3_reg) : 33'(den3_reg);
        side_next.w        = w3_reg;
        side_next.sd       = sd3_reg;
        side_next.part     = part_next;
        side_next.use_quad = q_on;
        side_next.den_zero = den3_reg == 33'sd0;
        side_next.num_neg  = mnum3_reg[63];
        side_next.num_zero = mnum3_reg == 64'sd0;
        side_next.q_neg    = mnum3_reg[63] ^ den3_reg[32];
        side_next.ovf      = {1'b0, nmag[63:32]} >= dmag;
        side_next.flag     = f3_reg;
    end

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            logic [33:0] t;
            t = {drem_reg[i], dlow_reg[i][31]};
            if (t >= {1'b0, ddiv_reg[i]})
            begin
                drem_next[i] = 33'(t - {1'b0, ddiv_reg[i]});
                dlow_next[i] = {dlow_reg[i][30:0], 1'b1};
            end
            else
            begin
                drem_next[i] = t[32:0];
                dlow_next[i] = {dlow_reg[i][30:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        qpwu_pkg::side_t sl;
        sl = dside_reg[NS];
        fq = 1'b0;
        qv = 64'sd0;
        if (sl.use_quad)
        begin
            if (sl.den_zero)
            begin
                fq = 1'b1;
                if (sl.num_zero)
                    qv = 64'sd0;
                else if (sl.num_neg)
                    qv = qpwu_pkg::W32_MIN;
                else
                    qv = qpwu_pkg::W32_MAX;
            end
            else if (sl.q_neg)
            begin
                if (sl.ovf || dlow_reg[NS] > 32'h8000_0000)
                begin
                    fq = 1'b1;
                    qv = qpwu_pkg::W32_MIN;
                end
                else
                begin
                    qv = -$signed({32'd0, dlow_reg[NS]});
                end
            end
            else
            begin
                if (sl.ovf || dlow_reg[NS] > 32'h7FFF_FFFF)
                begin
                    fq = 1'b1;
                    qv = qpwu_pkg::W32_MAX;
                end
                else
                begin
                    qv = $signed({32'd0, dlow_reg[NS]});
                end
            end
        end
        stsum = sl.part + qv;
        fs    = 1'b0;
        if (stsum > qpwu_pkg::W32_MAX)
        begin
            st_next = 32'(qpwu_pkg::W32_MAX);
            fs      = 1'b1;
        end
        else if (stsum < qpwu_pkg::W32_MIN)
        begin
            st_next = 32'(qpwu_pkg::W32_MIN);
            fs      = 1'b1;
        end
        else
        begin
            st_next = stsum[31:0];
        end
    end

    always_comb
    begin
        nw_sum = 33'(wf_reg) + 33'(stf_reg);
        fw     = 1'b0;
        if (nw_sum > 33'(qpwu_pkg::W32_MAX))
        begin
            nw_next = 32'(qpwu_pkg::W32_MAX);
            fw      = 1'b1;
        end
        else if (nw_sum < 33'(qpwu_pkg::W32_MIN))
        begin
            nw_next = 32'(qpwu_pkg::W32_MIN);
            fw      = 1'b1;
        end
        else
        begin
            nw_next = nw_sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            vf_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= NS; i++)
                dv_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            dv_reg[0]     <= v3_reg;
            for (int i = 0; i < NS; i++)
                dv_reg[i+1] <= dv_reg[i];
            vf_reg        <= dv_reg[NS];
            out_valid_reg <= vf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg   <= weight_in;
            d1_reg   <= last_step;
            s1_reg   <= slope_in;
            p1_reg   <= prev_slope_in;
            pdw1_reg <= 64'(decay_reg) * 64'(weight_in);

            w2_reg  <= w1_reg;
            d2_reg  <= d1_reg;
            p2_reg  <= p1_reg;
            sd2_reg <= sd_next;
            f2_reg  <= f2_next;

            w3_reg    <= w2_reg;
            d3_reg    <= d2_reg;
            sd3_reg   <= sd2_reg;
            f3_reg    <= f2_reg;
            meps3_reg <= 64'($signed({1'b0, eps_reg})) * 64'(sd2_reg);
            mmu3_reg  <= 64'($signed({1'b0, mu_reg})) * 64'(d2_reg);
            mthr3_reg <= 64'($signed({1'b0, shrink_reg})) * 64'(p2_reg);
            mnum3_reg <= 64'(d2_reg) * 64'(sd2_reg);
            den3_reg  <= 33'(p2_reg) - 33'(sd2_reg);

            dside_reg[0] <= side_next;
            drem_reg[0]  <= {1'b0, nmag[63:32]};
            dlow_reg[0]  <= nmag[31:0];
            ddiv_reg[0]  <= dmag;
            for (int i = 0; i < NS; i++)
            begin
                dside_reg[i+1] <= dside_reg[i];
                drem_reg[i+1]  <= drem_next[i];
                dlow_reg[i+1]  <= dlow_next[i];
                ddiv_reg[i+1]  <= ddiv_reg[i];
            end

            wf_reg  <= dside_reg[NS].w;
            sf_reg  <= dside_reg[NS].sd;
            stf_reg <= st_next;
            ff_reg  <= dside_reg[NS].flag | fq | fs;

            wo_reg <= nw_next;
            so_reg <= stf_reg;
            po_reg <= sf_reg;
            fo_reg <= ff_reg | fw;
        end
    end

    assign out_valid      = out_valid_reg;
    assign weight_out     = wo_reg;
    assign step_out       = so_reg;
    assign prev_slope_out = po_reg;
    assign saturated      = fo_reg;

    // saturate to max/min on a zero divisor (zero if the numerator is zero) and flag it
    a_den_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (en && dv_reg[NS] && dside_reg[NS].use_quad && dside_reg[NS].den_zero)
        |=> (vf_reg && ff_reg))
        else $error("zero divisor not flagged");

    a_quot_ovf_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (en && dv_reg[NS] && dside_reg[NS].use_quad && dside_reg[NS].ovf)
        |=> (vf_reg && ff_reg))
        else $error("quotient overflow not flagged");

    a_flag_carry: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vf_reg && ff_reg) |=> (out_valid_reg && fo_reg))
        else $error("saturation flag lost");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC = qpwu_pkg::FRAC_BITS_DEF;
    localparam int N_DIR = 16;
    localparam int N_RAND = 1130;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] d;
        logic signed [31:0] s;
        logic signed [31:0] p;
    } beat_t;

    typedef struct packed {
        logic signed [31:0] weight;
        logic signed [31:0] step;
        logic signed [31:0] slope;
        logic               sat;
    } upd_t;

    typedef struct packed {
        beat_t b;
        logic  typed;
        upd_t  e;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] weight_in = '0;
    logic signed [31:0] last_step = '0;
    logic signed [31:0] slope_in = '0;
    logic signed [31:0] prev_slope_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] weight_out;
    logic signed [31:0] step_out;
    logic signed [31:0] prev_slope_out;
    logic               saturated;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = qpwu_pkg::REG_EPSILON;
    logic [31:0]        cfg_data = '0;

    longint cur_eps, cur_decay, cur_mu, cur_shrink;
    upd_t   pending_upd[$];
    int     errors = 0;
    int     n_sent = 0;
    int     n_recv = 0;
    int     n_sat = 0;
    int     n_cfg = 0;
    bit     burst = 0;
    bit     hold_req = 0;

    row_t dir_tab[N_DIR] = '{
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 1'b0}},
        '{'{32'sh7fffffff, 32'sd0, -32'sd65536, 32'sd0}, 1'b1,
          '{32'sh7fffffff, 32'sd65536, -32'sd65536, 1'b1}},
        '{'{32'sh80000000, 32'sd0, 32'sd65536, 32'sd0}, 1'b1,
          '{32'sh80000000, -32'sd65536, 32'sd65536, 1'b1}},
        '{'{32'sd0, 32'sd0, 32'sh80000000, 32'sd0}, 1'b1,
          '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b1}},
        '{'{32'sd0, 32'sd65536, 32'sd65536, 32'sd65536}, 1'b0, '0},
        '{'{32'sd0, -32'sd65536, -32'sd65536, -32'sd65536}, 1'b0, '0},
        '{'{32'sd100, 32'sd65536, -32'sd65536, 32'sd0}, 1'b0, '0},
        '{'{32'sd100, -32'sd65536, 32'sd65536, 32'sd0}, 1'b0, '0},
        '{'{32'sd0, 32'sd65536, 32'sd32768, 32'sd16384}, 1'b0, '0},
        '{'{32'sd0, -32'sd65536, -32'sd32768, -32'sd16384}, 1'b0, '0},
        '{'{32'sd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000}, 1'b0, '0},
        '{'{32'sd0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, 32'sh7fffffff, 32'sh7fffffff}, 1'b0, '0},
        '{'{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000}, 1'b0, '0},
        '{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 1'b0, '0},
        '{'{32'sh7fffffff, -32'sd1, -32'sd1, 32'sd1}, 1'b0, '0}
    };

    quickprop_weight_update i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .weight_in      (weight_in),
        .last_step      (last_step),
        .slope_in       (slope_in),
        .prev_slope_in  (prev_slope_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .weight_out     (weight_out),
        .step_out       (step_out),
        .prev_slope_out (prev_slope_out),
        .saturated      (saturated),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint fx_mul(longint a, longint b);
        return (a * b) >>> FRAC;
    endfunction

    function automatic longint sat32(longint v, inout bit f);
        if (v > qpwu_pkg::W32_MAX)
        begin
            f = 1;
            return qpwu_pkg::W32_MAX;
        end
        if (v < qpwu_pkg::W32_MIN)
        begin
            f = 1;
            return qpwu_pkg::W32_MIN;
        end
        return v;
    endfunction

    function automatic longint quad_term(longint d, longint s, longint p, inout bit f);
        longint num;
        longint den;
        num = d * s;
        den = p - s;
        if (den == 0)
        begin
            f = 1;
            if (num > 0)
                return qpwu_pkg::W32_MAX;
            if (num < 0)
                return qpwu_pkg::W32_MIN;
            return 0;
        end
        return sat32(num / den, f);
    endfunction

    function automatic upd_t predict_update(beat_t b);
        longint w, d, s, p, thr, step, nw;
        bit     f;
        upd_t   r;
        f = 0;
        w = b.w;
        d = b.d;
        p = b.p;
        s = sat32(longint'(b.s) + fx_mul(cur_decay, w), f);
        thr = fx_mul(cur_shrink, p);
        step = 0;
        if (d < 0)
        begin
            if (s > 0)
                step -= fx_mul(cur_eps, s);
            if (s >= thr)
                step += fx_mul(cur_mu, d);
            else
                step += quad_term(d, s, p, f);
        end
        else if (d > 0)
        begin
            if (s < 0)
                step -= fx_mul(cur_eps, s);
            if (s <= thr)
                step += fx_mul(cur_mu, d);
            else
                step += quad_term(d, s, p, f);
        end
        else
            step -= fx_mul(cur_eps, s);
        step = sat32(step, f);
        nw = sat32(w + step, f);
        r.weight = nw[31:0];
        r.step = step[31:0];
        r.slope = s[31:0];
        r.sat = f;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return 32'($urandom_range(0, 262143)) - 32'd131072;
            3: return 32'($urandom_range(0, 4194303)) - 32'd2097152;
            4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($urandom_range(0, 31)) - 32'd16;
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_upd.size() != 0)
            @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            qpwu_pkg::REG_EPSILON: cur_eps = longint'(val[30:0]);
            qpwu_pkg::REG_DECAY:   cur_decay = longint'(signed'(val));
            qpwu_pkg::REG_MU:      cur_mu = longint'(val[30:0]);
            default:               cur_shrink = longint'(val[30:0]);
        endcase
    endtask

    task automatic load_config(logic [31:0] eps, logic [31:0] dec, logic [31:0] m,
                               logic [31:0] shr);
        in_valid <= 1'b0;
        wait_drained();
        write_reg(qpwu_pkg::REG_EPSILON, eps);
        write_reg(qpwu_pkg::REG_DECAY, dec);
        write_reg(qpwu_pkg::REG_MU, m);
        write_reg(qpwu_pkg::REG_SHRINK, shr);
        n_cfg++;
    endtask

    task automatic send_beat(beat_t b, logic typed, upd_t e);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        weight_in <= b.w;
        last_step <= b.d;
        slope_in <= b.s;
        prev_slope_in <= b.p;
        do
            @(posedge clk);
        while (!in_ready);
        pending_upd.push_back(typed ? e : predict_update(b));
        n_sent++;
    endtask

    task automatic send_random(int n);
        beat_t b;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                burst = !burst;
            b.w = rand_word();
            b.d = rand_word();
            b.s = rand_word();
            b.p = $urandom_range(0, 9) == 0 ? b.s : rand_word();
            send_beat(b, 1'b0, '0);
        end
    endtask

    always
    begin
        int stall;
        @(posedge clk);
        if (rst_n)
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 0;
            end
            stall = burst ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        upd_t e;
        if (rst_n && out_valid && out_ready)
        begin
            n_recv++;
            if (pending_upd.size() == 0)
            begin
                $display("%0t: unexpected beat weight=%h step=%h slope=%h sat=%b", $time,
                         weight_out, step_out, prev_slope_out, saturated);
                errors++;
            end
            else
            begin
                e = pending_upd.pop_front();
                if (e.sat)
                    n_sat++;
                if (weight_out !== e.weight)
                begin
                    $display("%0t: weight_out exp %h got %h", $time, e.weight, weight_out);
                    errors++;
                end
                if (step_out !== e.step)
                begin
                    $display("%0t: step_out exp %h got %h", $time, e.step, step_out);
                    errors++;
                end
                if (prev_slope_out !== e.slope)
                begin
                    $display("%0t: prev_slope_out exp %h got %h", $time, e.slope,
                             prev_slope_out);
                    errors++;
                end
                if (saturated !== e.sat)
                begin
                    $display("%0t: saturated exp %b got %b", $time, e.sat, saturated);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("quickprop_weight_update test failed");
        $finish;
    end

    initial
    begin
        cur_eps = qpwu_pkg::EPSILON_RST;
        cur_decay = qpwu_pkg::DECAY_RST;
        cur_mu = qpwu_pkg::MU_RST;
        cur_shrink = qpwu_pkg::SHRINK_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_beat(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].e);
        send_random(150);

        load_config(32'hffffffff, 32'h7fffffff, 32'hffffffff, 32'h0);
        send_random(150);

        load_config(32'h0, 32'h80000000, 32'h0, 32'h7fffffff);
        send_random(150);

        // fill the pipe against a stalled output
        load_config(32'd6554, 32'hffffff00, 32'd114688, 32'd41704);
        hold_req = 1;
        burst = 1;
        send_random(200);
        burst = 0;

        load_config($urandom, $urandom, $urandom, $urandom);
        send_random(200);

        load_config(32'd65536, 32'h0, 32'd114688, 32'd41704);
        send_random(N_RAND - 850);

        in_valid <= 1'b0;
        wait_drained();
        $display("%0d beats sent, %0d checked, %0d saturating, across %0d register settings",
                 n_sent, n_recv, n_sat, n_cfg + 1);
        if (errors == 0)
            $display("quickprop_weight_update test passed");
        else
            $display("quickprop_weight_update test failed");
        $finish;
    end

endmodule

// ===== quickprop_weight_update.f =====
src/qpwu_pkg.sv
src/quickprop_weight_update.sv
tb/tb_top.sv
